/* design/ite_pkg.sv */
// ite_pkg: shared types, codes and helpers for the indexed texture expander
package ite_pkg;

  // palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // result slots per source element (2x2 doubling)
  localparam int SLOTS = 4;

  // item opcodes
  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } opcode_t;

  // pixel formats; the fourth code behaves as direct rgba
  localparam logic [1:0] FMT_DIRECT = 2'd0;
  localparam logic [1:0] FMT_INDEX8 = 2'd1;
  localparam logic [1:0] FMT_INDEX4 = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_DOUBLED      = 3'd1;
  localparam logic [2:0] CFG_HALF_SIZE    = 3'd2;
  localparam logic [2:0] CFG_SUB_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_SUB_HEIGHT   = 3'd4;
  localparam logic [2:0] CFG_DEST_STRIDE  = 3'd5;
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd6;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd7;

  // placement geometry
  typedef enum logic [1:0] {
    GEO_COPY,
    GEO_HALF,
    GEO_DOUBLE
  } geo_t;

  // input item
  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  palette_slot;
    logic [31:0] element;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] dest_index;
    logic [31:0] pixel_value;
    logic        last;
  } out_item_t;

  // raster position
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic wrap;
  } adv_t;

  // step one pixel along the raster, wrapping to the origin at the end
  function automatic adv_t pos_advance(pos_t p, logic [15:0] rw, logic [15:0] rh);
    logic [16:0] c;
    logic [16:0] r;
    adv_t        a;
    c      = {1'b0, p.col} + 17'd1;
    r      = {1'b0, p.row};
    a.wrap = 1'b0;
    if (c >= {1'b0, rw}) begin
      c = 17'd0;
      r = r + 17'd1;
      if (r >= {1'b0, rh}) begin
        r      = 17'd0;
        a.wrap = 1'b1;
      end
    end
    a.pos.row = r[15:0];
    a.pos.col = c[15:0];
    return a;
  endfunction

endpackage

/* design/ite_ram.sv */
// ite_ram: generic simple dual-port ram with registered read
module ite_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/indexed_texture_expander_unit.sv */
// indexed_texture_expander_unit: palette texture expander with half size and 2x2 doubling
//
// Palette words and source elements share the input channel and are handled strictly in
// order. Each result item leaves on the output channel at up to one per cycle while the
// output is not stalled: an element occupies the emitter until all of its results (1 for
// copy, 0 or 1 for half size, 1 or 2 for four-bit indices, up to 4 for 2x2 doubling) have
// been emitted, and a palette write or an element without results emits nothing. A new
// item is taken in the cycle in which the previous one finishes, so the sustained rate is
// set by the emitter's one-result-per-cycle output slot. After acceptance an item passes
// through the job register, then the palette read stage (row and column formed, registered
// ram read), then the output register, where row times stride plus column is formed. The
// palette is a 256 x 32 ram that is written in the job stage, so later elements always see
// earlier palette writes; entries are undefined until written and there is no clearing
// pass. The nibble phase of four-bit data never outlives an item. Configuration may only
// change while the block is idle.
module indexed_texture_expander_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ite_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ite_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  import ite_pkg::*;

  // configuration registers
  logic [1:0]  fmt_r;
  logic        doubled_r;
  logic        half_r;
  logic [15:0] sub_w_r;
  logic [15:0] sub_h_r;
  logic [15:0] stride_r;
  logic [15:0] org_x_r;
  logic [15:0] org_y_r;

  // raster position
  pos_t        pos_r;
  pos_t        pos_nxt;

  // job stage
  logic        j_valid_r;
  in_item_t    j_item_r;
  pos_t        j_p0_r;
  pos_t        j_p1_r;
  logic        j_two_r;
  logic        j_pix_r;
  logic [SLOTS-1:0] j_done_r;

  // palette read stage
  logic        m_valid_r;
  logic [17:0] m_row_r;
  logic [17:0] m_col_r;
  logic [31:0] m_value_r;
  logic        m_use_pal_r;
  logic        m_in_range_r;
  logic        m_last_r;

  // output register
  logic        out_valid_r;
  out_item_t   out_item_r;

  // combinational signals
  logic        is_nib;
  geo_t        geo;
  logic [15:0] rw;
  logic [15:0] rh;
  logic        raster_empty;
  logic        restart;
  pos_t        pos_start;
  adv_t        a1;
  adv_t        a2;
  logic        in_fire;
  logic        pix_fire;
  logic [15:0] bx;
  logic [15:0] by;
  logic [16:0] sum_rows;
  logic [16:0] sum_cols;
  logic [15:0] rows_h;
  logic [15:0] cols_h;
  logic        half_ok;
  logic        row_ok0;
  logic        row_ok1;
  logic        col_ok0;
  logic        col_ok1;
  logic [SLOTS-1:0] mask;
  logic [SLOTS-1:0] remaining;
  logic [SLOTS-1:0] sel;
  logic        more;
  logic        dx;
  logic        dy;
  logic        o_adv;
  logic        m_space;
  logic        emit_fire;
  logic        j_finish;
  pos_t        slot_pos;
  logic [16:0] row_off;
  logic [16:0] col_off;
  logic [7:0]  pal_idx;
  logic        use_pal;
  logic        in_range;
  logic        pal_we;
  logic [31:0] pal_rdata;
  logic [33:0] dest_full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_DIRECT;
      doubled_r <= 1'b0;
      half_r    <= 1'b0;
      sub_w_r   <= '0;
      sub_h_r   <= '0;
      stride_r  <= '0;
      org_x_r   <= '0;
      org_y_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: fmt_r     <= cfg_wdata[1:0];
        CFG_DOUBLED:      doubled_r <= cfg_wdata[0];
        CFG_HALF_SIZE:    half_r    <= cfg_wdata[0];
        CFG_SUB_WIDTH:    sub_w_r   <= cfg_wdata;
        CFG_SUB_HEIGHT:   sub_h_r   <= cfg_wdata;
        CFG_DEST_STRIDE:  stride_r  <= cfg_wdata;
        CFG_ORIGIN_X:     org_x_r   <= cfg_wdata;
        CFG_ORIGIN_Y:     org_y_r   <= cfg_wdata;
      endcase
    end
  end

  // geometry and raster size from configuration
  always_comb begin
    is_nib = (fmt_r == FMT_INDEX4);
    priority if (is_nib) begin
      geo = GEO_COPY;
    end else if (doubled_r) begin
      geo = half_r ? GEO_COPY : GEO_DOUBLE;
    end else begin
      geo = half_r ? GEO_HALF : GEO_COPY;
    end
    if (!is_nib && doubled_r) begin
      rw = 16'(({1'b0, sub_w_r} + 17'd1) >> 1);
      rh = 16'(({1'b0, sub_h_r} + 17'd1) >> 1);
    end else begin
      rw = sub_w_r;
      rh = sub_h_r;
    end
    raster_empty = (rw == 16'd0) || (rh == 16'd0);
    bx = half_r ? {1'b0, org_x_r[15:1]} : org_x_r;
    by = half_r ? {1'b0, org_y_r[15:1]} : org_y_r;
    sum_rows = {1'b0, sub_h_r} + {1'b0, org_y_r};
    sum_cols = {1'b0, sub_w_r} + {1'b0, org_x_r};
    rows_h   = sum_rows[16:1] - {1'b0, org_y_r[15:1]};
    cols_h   = sum_cols[16:1] - {1'b0, org_x_r[15:1]};
  end

  // raster position update at acceptance
  always_comb begin
    in_fire   = in_valid && in_ready;
    pix_fire  = in_fire && (in_item.opcode == OP_PIXEL) && !raster_empty;
    restart   = (pos_r.col >= rw) || (pos_r.row >= rh);
    pos_start = restart ? '0 : pos_r;
    a1        = pos_advance(pos_start, rw, rh);
    a2        = pos_advance(a1.pos, rw, rh);
    pos_nxt   = pos_r;
    if (pix_fire) begin
      pos_nxt = (is_nib && !a1.wrap) ? a2.pos : a1.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // result mask of the current job
  always_comb begin
    half_ok = !j_p0_r.row[0] && !j_p0_r.col[0] &&
              ({1'b0, j_p0_r.row[15:1]} < rows_h) && ({1'b0, j_p0_r.col[15:1]} < cols_h);
    row_ok0 = {j_p0_r.row, 1'b0} < {1'b0, sub_h_r};
    row_ok1 = {j_p0_r.row, 1'b1} < {1'b0, sub_h_r};
    col_ok0 = {j_p0_r.col, 1'b0} < {1'b0, sub_w_r};
    col_ok1 = {j_p0_r.col, 1'b1} < {1'b0, sub_w_r};
    if (!j_pix_r) begin
      mask = '0;
    end else if (is_nib) begin
      mask = {2'b00, j_two_r, 1'b1};
    end else begin
      case (geo)
        GEO_COPY:   mask = 4'b0001;
        GEO_HALF:   mask = {3'b000, half_ok};
        GEO_DOUBLE: mask = {row_ok1 && col_ok1, row_ok1 && col_ok0,
                            row_ok0 && col_ok1, row_ok0 && col_ok0};
        default:    mask = '0;
      endcase
    end
  end

  // pick the next result slot and handshake the stages
  always_comb begin
    remaining = mask & ~j_done_r;
    sel       = remaining & (~remaining + 4'd1);
    more      = |(remaining & ~sel);
    dx        = sel[1] || sel[3];
    dy        = sel[2] || sel[3];
    o_adv     = !out_valid_r || out_ready;
    m_space   = !m_valid_r || o_adv;
    emit_fire = j_valid_r && (|remaining) && m_space;
    j_finish  = j_valid_r && (!(|remaining) || (emit_fire && !more));
    in_ready  = !j_valid_r || j_finish;
  end

  // destination offsets and palette index of the selected slot
  always_comb begin
    slot_pos = (is_nib && sel[1]) ? j_p1_r : j_p0_r;
    row_off  = {1'b0, slot_pos.row};
    col_off  = {1'b0, slot_pos.col};
    if (!is_nib) begin
      case (geo)
        GEO_HALF: begin
          row_off = {2'b00, j_p0_r.row[15:1]};
          col_off = {2'b00, j_p0_r.col[15:1]};
        end
        GEO_DOUBLE: begin
          row_off = {j_p0_r.row, dy};
          col_off = {j_p0_r.col, dx};
        end
        default: begin
          row_off = {1'b0, j_p0_r.row};
          col_off = {1'b0, j_p0_r.col};
        end
      endcase
    end
    if (is_nib) begin
      pal_idx = sel[1] ? {4'h0, j_item_r.element[7:4]} : {4'h0, j_item_r.element[3:0]};
    end else begin
      pal_idx = j_item_r.element[7:0];
    end
    use_pal  = is_nib || (fmt_r == FMT_INDEX8);
    in_range = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);
    pal_we   = j_valid_r && (j_item_r.opcode == OP_PALETTE) &&
               ({1'b0, j_item_r.palette_slot} < 9'(PALETTE_DEPTH));
  end

  // job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r <= 1'b0;
      j_done_r  <= '0;
    end else if (in_fire) begin
      j_valid_r <= 1'b1;
      j_done_r  <= '0;
    end else begin
      if (j_finish) begin
        j_valid_r <= 1'b0;
      end
      if (emit_fire) begin
        j_done_r <= j_done_r | sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      j_item_r <= in_item;
      j_p0_r   <= pos_start;
      j_p1_r   <= a1.pos;
      j_two_r  <= !a1.wrap;
      j_pix_r  <= (in_item.opcode == OP_PIXEL) && !raster_empty;
    end
  end

  // palette memory: written in job order, read as a slot is emitted
  ite_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_we),
    .wr_addr (j_item_r.palette_slot[PAL_AW-1:0]),
    .wr_data (j_item_r.element),
    .rd_en   (emit_fire && use_pal),
    .rd_addr (pal_idx[PAL_AW-1:0]),
    .rd_data (pal_rdata)
  );

  // palette read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (emit_fire) begin
      m_valid_r <= 1'b1;
    end else if (o_adv) begin
      m_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_row_r      <= {2'b00, by} + {1'b0, row_off};
      m_col_r      <= {2'b00, bx} + {1'b0, col_off};
      m_value_r    <= j_item_r.element;
      m_use_pal_r  <= use_pal;
      m_in_range_r <= in_range;
      m_last_r     <= !more;
    end
  end

  // output register: row times stride plus column
  assign dest_full = ({16'h0000, m_row_r} * {18'h00000, stride_r}) + {16'h0000, m_col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_adv) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && m_valid_r) begin
      out_item_r.dest_index  <= dest_full[31:0];
      out_item_r.pixel_value <= !m_use_pal_r ? m_value_r :
                                (m_in_range_r ? pal_rdata : 32'h0);
      out_item_r.last        <= m_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // read stage holds its slot while the output is stalled
  a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r && !o_adv |=> m_valid_r && $stable(m_row_r) && $stable(m_col_r))
    else $error("read stage lost its slot under stall");

  // position stays inside the raster after an element
  a_pos_in_raster: assert property (@(posedge clk) disable iff (!rst_n)
    pix_fire |=> (pos_r.row < $past(rh)) && (pos_r.col < $past(rw)))
    else $error("raster position left the raster");

  // a palette write emits nothing and finishes without stalling the job stage
  a_write_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    j_valid_r && (j_item_r.opcode == OP_PALETTE) |-> !emit_fire && j_finish)
    else $error("palette write emitted a result");

  // exactly one slot is chosen per emitted result
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> $onehot(sel) && ((sel & j_done_r) == '0))
    else $error("bad slot selection");

endmodule
